### design/mtws_pkg.sv
package mtws_pkg;

  // Field widths of the request and response words
  localparam int ACT_W  = 2;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 3;
  localparam int STAT_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_REGISTER = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CHECKIN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHECK    = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERDUE  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEEK,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // latch request word, clear scan index and flags
    logic step;     // advance scan index
    logic scan;     // issue a slot compare for the current index
    logic claim;    // claim slot at scan index
    logic checkin;  // stamp time on requested slot
    logic push;     // move result into the response register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             free_here;   // slot at scan index is free
    logic             idx_last;    // scan index is the last slot
    logic             table_full;
    logic             slot_ok;     // check-in slot exists and is registered
    logic             out_free;    // response register can take a word
  } stat_t;

endpackage

### design/mtws_req_if.sv
interface mtws_req_if;
  logic                           valid;
  logic                           ready;
  logic [mtws_pkg::ACT_W-1:0]     action;
  logic [mtws_pkg::TIME_W-1:0]    allow_ms;
  logic [mtws_pkg::SLOT_W-1:0]    task_slot;
  logic [mtws_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, action, allow_ms, task_slot, now_ms, input ready);
  modport sink   (input valid, action, allow_ms, task_slot, now_ms, output ready);
endinterface

### design/mtws_rsp_if.sv
interface mtws_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mtws_pkg::STAT_W-1:0]    status;
  logic [mtws_pkg::SLOT_W-1:0]    assigned_slot;
  logic                           feed_pulse;

  modport source (output valid, status, assigned_slot, feed_pulse, input ready);
  modport sink   (input valid, status, assigned_slot, feed_pulse, output ready);
endinterface

### design/mtws_ctrl.sv
module mtws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtws_pkg::stat_t   stat,
  output mtws_pkg::cmd_t    cmd
);

  mtws_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtws_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      mtws_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mtws_pkg::S_DECODE;
        end
      end
      mtws_pkg::S_DECODE: begin
        case (stat.act)
          mtws_pkg::ACT_REGISTER: begin
            state_next = stat.table_full ? mtws_pkg::S_FINISH : mtws_pkg::S_SEEK;
          end
          mtws_pkg::ACT_CHECKIN: begin
            cmd.checkin = stat.slot_ok;
            state_next  = mtws_pkg::S_FINISH;
          end
          mtws_pkg::ACT_CHECK: begin
            state_next = mtws_pkg::S_SCAN;
          end
          default: begin
            state_next = mtws_pkg::S_FINISH;
          end
        endcase
      end
      // lowest free slot search; a free one exists since the table is not full
      mtws_pkg::S_SEEK: begin
        if (stat.free_here) begin
          cmd.claim  = 1'b1;
          state_next = mtws_pkg::S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      mtws_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        cmd.step = 1'b1;
        if (stat.idx_last) begin
          state_next = mtws_pkg::S_DRAIN;
        end
      end
      // last compare lands this cycle
      mtws_pkg::S_DRAIN: begin
        state_next = mtws_pkg::S_FINISH;
      end
      mtws_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = mtws_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mtws_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/mtws_datapath.sv
module mtws_datapath #(
  parameter int MAX_TASKS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mtws_pkg::ACT_W-1:0]    in_action,
  input  logic [mtws_pkg::TIME_W-1:0]   in_allow_ms,
  input  logic [mtws_pkg::SLOT_W-1:0]   in_task_slot,
  input  logic [mtws_pkg::TIME_W-1:0]   in_now_ms,
  input  mtws_pkg::cmd_t                cmd,
  output mtws_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtws_pkg::STAT_W-1:0]   out_status,
  output logic [mtws_pkg::SLOT_W-1:0]   out_assigned_slot,
  output logic                          out_feed_pulse
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // Latched request word
  logic [mtws_pkg::ACT_W-1:0]  act_q;
  logic [mtws_pkg::TIME_W-1:0] tmo_q;
  logic [mtws_pkg::SLOT_W-1:0] slot_q;
  logic [mtws_pkg::TIME_W-1:0] now_q;

  // Slot table: flags in flops, timeouts and stamps in memories
  logic [MAX_TASKS-1:0]        used;
  logic [CNT_W-1:0]            count;
  logic [mtws_pkg::TIME_W-1:0] mem_tmo  [MAX_TASKS];
  logic [mtws_pkg::TIME_W-1:0] mem_seen [MAX_TASKS];
  logic [mtws_pkg::TIME_W-1:0] rd_tmo;
  logic [mtws_pkg::TIME_W-1:0] rd_seen;

  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            slot_idx;
  logic                        slot_in_range;
  logic                        pipe_vld;
  logic                        overdue;
  logic [mtws_pkg::TIME_W-1:0] elapsed;

  // Pending result for register and check-in
  logic [mtws_pkg::STAT_W-1:0] rs_status;
  logic [mtws_pkg::SLOT_W-1:0] rs_slot;

  assign slot_in_range = {{(32-mtws_pkg::SLOT_W){1'b0}}, slot_q} < MAX_TASKS;
  assign slot_idx      = IDX_W'(slot_q);
  assign elapsed       = now_q - rd_seen;

  assign stat.act        = act_q;
  assign stat.free_here  = ~used[idx];
  assign stat.idx_last   = (idx == IDX_W'(MAX_TASKS - 1));
  assign stat.table_full = (count == CNT_W'(MAX_TASKS));
  assign stat.slot_ok    = slot_in_range && used[slot_idx];
  assign stat.out_free   = ~out_valid || out_ready;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= in_action;
      tmo_q  <= in_allow_ms;
      slot_q <= in_task_slot;
      now_q  <= in_now_ms;
    end
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
    end
  end

  // Registered flags and count
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else if (cmd.claim) begin
      used[idx] <= 1'b1;
      count     <= count + 1'b1;
    end
  end

  // Timeout memory
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      mem_tmo[idx] <= tmo_q;
    end
    rd_tmo <= mem_tmo[idx];
  end

  // Check-in stamp memory: zeroed on claim, stamped on check-in
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      mem_seen[idx] <= '0;
    end else if (cmd.checkin) begin
      mem_seen[slot_idx] <= now_q;
    end
    rd_seen <= mem_seen[idx];
  end

  // Overdue compare, one slot per cycle, in the cycle after its read address
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= cmd.scan && used[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      overdue <= 1'b0;
    end else if (pipe_vld && (elapsed > rd_tmo)) begin
      overdue <= 1'b1;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rs_status <= mtws_pkg::ST_REJECTED;
      rs_slot   <= '0;
    end else if (cmd.claim) begin
      rs_status <= mtws_pkg::ST_OK;
      rs_slot   <= mtws_pkg::SLOT_W'(idx);
    end else if (cmd.checkin) begin
      rs_status <= mtws_pkg::ST_OK;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (act_q == mtws_pkg::ACT_CHECK) begin
        out_status     <= overdue ? mtws_pkg::ST_OVERDUE : mtws_pkg::ST_OK;
        out_feed_pulse <= ~overdue;
      end else begin
        out_status     <= rs_status;
        out_feed_pulse <= 1'b0;
      end
      out_assigned_slot <= rs_slot;
    end
  end

endmodule

### design/multi_task_watchdog_supervisor_unit.sv
// Channel  Dir  Fields                                      Accept
// req      in   action, allow_ms, task_slot, now_ms         req.valid && req.ready
// rsp      out  status, assigned_slot, feed_pulse           rsp.valid && rsp.ready
//
// One word at a time. Register searches for the lowest free slot, one slot per
// cycle, and is rejected without a search when the table is full; check-in
// needs no search; check runs a one-slot-per-cycle scan over all of the table
// memories (one read port each, registered read data).
// Synchronous reset clears the slot flags and count; no clearing pass is needed.
// The result sits in an output register: a stalled rsp holds only the word
// after it, which waits in the finish state; req.ready is high only when idle.
module multi_task_watchdog_supervisor_unit #(
  parameter int MAX_TASKS = 8
) (
  input  logic         clk,
  input  logic         rst,
  mtws_req_if.sink     req,
  mtws_rsp_if.source   rsp
);

  mtws_pkg::cmd_t  cmd;
  mtws_pkg::stat_t stat;

  mtws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtws_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .in_action         (req.action),
    .in_allow_ms       (req.allow_ms),
    .in_task_slot      (req.task_slot),
    .in_now_ms         (req.now_ms),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_assigned_slot (rsp.assigned_slot),
    .out_feed_pulse    (rsp.feed_pulse)
  );

endmodule
